// ===== hdl/glpg_pkg.sv =====
// shared types, constants and codes of the grid line position generator
package glpg_pkg;

  localparam int MAX_LINES  = 64;
  localparam int LINE_CNT_W = 6;
  localparam logic [LINE_CNT_W-1:0] LAST_LINE = LINE_CNT_W'(MAX_LINES - 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // restoring divider: 61-bit dividend, 46-bit divisor, one quotient bit a cycle
  localparam int DIV_NW    = 61;
  localparam int DIV_DW    = 46;
  localparam int DIV_CNT_W = 6;

  localparam logic [35:0] RES_MIN   = 36'd16384;
  localparam logic [35:0] RES_MAX   = 36'd65536000;
  localparam logic [17:0] FONT_MIN  = 18'd64;
  localparam logic [17:0] FONT_MAX  = 18'd256000;
  localparam logic [8:0]  MZP_MIN   = 9'd10;
  localparam logic [8:0]  MZP_MAX   = 9'd400;
  localparam logic [27:0] ZOOM_PCT  = 28'd100;
  localparam logic [53:0] VIS_MIN   = 54'h0_0001_0000_0000;

  localparam int EN_GRID = 0;
  localparam int EN_HORZ = 1;
  localparam int EN_VERT = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE_MASK  = 3'd0,
    REG_UNIT_IS_EM   = 3'd1,
    REG_HSTEP        = 3'd2,
    REG_VSTEP        = 3'd3,
    REG_FONT_SIZE    = 3'd4,
    REG_AXIS_OFFSET  = 3'd5,
    REG_MAJOR_EVERY  = 3'd6,
    REG_MIN_ZOOM     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESH,
    ST_RESV,
    ST_SCALE,
    ST_BASE,
    ST_CHECK,
    ST_DIV,
    ST_FIRST,
    ST_MOD,
    ST_ALIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               axis;
    logic [23:0]        viewport_extent;
    logic signed [31:0] scroll_offset;
    logic [19:0]        zoom;
    logic signed [31:0] grid_origin;
  } in_item_t;

  typedef struct packed {
    logic [23:0] position;
    logic        is_major;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]         enable_mask;
    logic               unit_is_em;
    logic [17:0]        horizontal_step;
    logic [17:0]        vertical_step;
    logic [17:0]        font_size;
    logic signed [23:0] axis_offset;
    logic [7:0]         major_every;
    logic [8:0]         min_zoom_percent;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_NW-1:0] quotient;
    logic [DIV_DW-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== hdl/glpg_cfg.sv =====
// configuration register file with the static range checks
module glpg_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [glpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glpg_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output glpg_pkg::cfg_t                   cfg,
  output logic                             static_ok
);

  glpg_pkg::cfg_t cfg_r;
  glpg_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (glpg_pkg::cfg_reg_t'(cfg_index))
        glpg_pkg::REG_ENABLE_MASK: cfg_nxt.enable_mask      = cfg_wdata[2:0];
        glpg_pkg::REG_UNIT_IS_EM:  cfg_nxt.unit_is_em       = cfg_wdata[0];
        glpg_pkg::REG_HSTEP:       cfg_nxt.horizontal_step  = cfg_wdata[17:0];
        glpg_pkg::REG_VSTEP:       cfg_nxt.vertical_step    = cfg_wdata[17:0];
        glpg_pkg::REG_FONT_SIZE:   cfg_nxt.font_size        = cfg_wdata[17:0];
        glpg_pkg::REG_AXIS_OFFSET: cfg_nxt.axis_offset      = $signed(cfg_wdata[23:0]);
        glpg_pkg::REG_MAJOR_EVERY: cfg_nxt.major_every      = cfg_wdata[7:0];
        glpg_pkg::REG_MIN_ZOOM:    cfg_nxt.min_zoom_percent = cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_mask      <= 3'd0;
      cfg_r.unit_is_em       <= 1'b0;
      cfg_r.horizontal_step  <= 18'd6144;
      cfg_r.vertical_step    <= 18'd6144;
      cfg_r.font_size        <= 18'd4096;
      cfg_r.axis_offset      <= 24'sd0;
      cfg_r.major_every      <= 8'd4;
      cfg_r.min_zoom_percent <= 9'd50;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // resolved step ranges are checked by the sequencer, they need a multiply
  assign static_ok = (cfg_r.font_size >= glpg_pkg::FONT_MIN) &&
                     (cfg_r.font_size <= glpg_pkg::FONT_MAX) &&
                     (cfg_r.major_every != 8'd0) &&
                     (cfg_r.min_zoom_percent >= glpg_pkg::MZP_MIN) &&
                     (cfg_r.min_zoom_percent <= glpg_pkg::MZP_MAX);

  assign cfg = cfg_r;

endmodule

// ===== hdl/glpg_div.sv =====
// shared restoring divider, one quotient bit per cycle
module glpg_div (
  input  logic               clk,
  input  logic               rst_n,
  input  glpg_pkg::div_req_t req,
  output glpg_pkg::div_rsp_t rsp
);

  logic                             busy_r, busy_nxt;
  logic                             done_r, done_nxt;
  logic [glpg_pkg::DIV_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [glpg_pkg::DIV_NW-1:0]      quo_r, quo_nxt;
  logic [glpg_pkg::DIV_DW-1:0]      rem_r, rem_nxt;
  logic [glpg_pkg::DIV_DW-1:0]      dvs_r, dvs_nxt;
  logic [glpg_pkg::DIV_DW:0]        trial;
  logic [glpg_pkg::DIV_DW:0]        diff;
  logic                             ge;

  always_comb begin
    trial    = {rem_r, quo_r[glpg_pkg::DIV_NW-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = trial >= {1'b0, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = glpg_pkg::DIV_CNT_W'(glpg_pkg::DIV_NW - 1);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // partial remainder stays below the divisor, so the top bit drops out
      rem_nxt = ge ? diff[glpg_pkg::DIV_DW-1:0] : trial[glpg_pkg::DIV_DW-1:0];
      quo_nxt = {quo_r[glpg_pkg::DIV_NW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== hdl/grid_line_position_generator.sv =====
// top level: request sequencer, line stepper and output register
// One request runs through the set-up states (step resolve for both axes, zoom scaling, base
// product), then two passes on the shared restoring divider (first line index, then that index
// modulo major_every), one alignment step, and finally one line per cycle while out_ready is
// high, up to 64 lines; in_ready is high only between requests. Disabled, out-of-range or empty
// requests end without any line. The last line of a request carries last=1; the output register
// lets the next request be taken while that line waits.
module grid_line_position_generator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  glpg_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output glpg_pkg::out_item_t              out_item,
  input  logic                             cfg_we,
  input  logic [glpg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [glpg_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  glpg_pkg::cfg_t      cfg;
  logic                static_ok;
  glpg_pkg::div_req_t  div_req;
  glpg_pkg::div_rsp_t  div_rsp;

  glpg_pkg::state_t    state_r, state_nxt;
  glpg_pkg::in_item_t  in_r, in_nxt;
  logic                rh_ok_r, rh_ok_nxt;
  logic                ok_r, ok_nxt;
  logic [25:0]         r_r, r_nxt;
  logic signed [33:0]  diff_r, diff_nxt;
  logic [45:0]         s_r, s_nxt;
  logic                minor_r, minor_nxt;
  logic [53:0]         vis_r, vis_nxt;
  logic signed [53:0]  prod_r, prod_nxt;
  logic                neg_r, neg_nxt;
  logic [60:0]         first_mag_r, first_mag_nxt;
  logic [55:0]         pos_r, pos_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic [7:0]          adj_r, adj_nxt;
  logic [glpg_pkg::LINE_CNT_W-1:0] n_r, n_nxt;
  logic                out_valid_r, out_valid_nxt;
  glpg_pkg::out_item_t out_item_r, out_item_nxt;

  logic [17:0]         res_step;
  logic [35:0]         res_prod;
  logic                res_ok;
  logic                axis_on;
  logic                go;
  logic [45:0]         s_prod;
  logic                minor_cmp;
  logic [53:0]         vis_prod;
  logic signed [53:0]  base_prod;
  logic [52:0]         prod_mag;
  logic                num_pos;
  logic [7:0]          mod_u;
  logic [7:0]          mod_p;
  logic [7:0]          cnt_inc;
  logic [53:0]         align_prod;
  logic [56:0]         lim;
  logic [56:0]         pos_ext;
  logic [56:0]         step_pos;
  logic                out_free;
  logic                load_item;
  logic                is_last;

  glpg_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .static_ok (static_ok)
  );

  glpg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    res_step   = (state_r == glpg_pkg::ST_RESV) ? cfg.vertical_step : cfg.horizontal_step;
    res_prod   = cfg.unit_is_em ? 36'(res_step) * 36'(cfg.font_size) : {10'd0, res_step, 8'd0};
    res_ok     = (res_prod >= glpg_pkg::RES_MIN) && (res_prod <= glpg_pkg::RES_MAX);
    axis_on    = in_r.axis ? cfg.enable_mask[glpg_pkg::EN_VERT]
                           : cfg.enable_mask[glpg_pkg::EN_HORZ];
    go         = cfg.enable_mask[glpg_pkg::EN_GRID] && axis_on && static_ok && ok_r &&
                 (in_r.viewport_extent != 24'd0) && (in_r.zoom != 20'd0);
    s_prod     = 46'(r_r) * 46'(in_r.zoom);
    minor_cmp  = (28'(in_r.zoom) * glpg_pkg::ZOOM_PCT) >= {3'd0, cfg.min_zoom_percent, 16'd0};
    vis_prod   = 54'(s_r) * 54'(cfg.major_every);
    base_prod  = 54'(diff_r) * 54'($signed({1'b0, in_r.zoom}));
    // base is prod_r * 256; a negative base means a positive numerator
    num_pos    = prod_r[53];
    prod_mag   = num_pos ? 53'(-prod_r) : 53'(prod_r);
    mod_u      = div_rsp.remainder[7:0];
    mod_p      = (neg_r && (mod_u != 8'd0)) ? (cfg.major_every - mod_u) : mod_u;
    cnt_inc    = cnt_r + 8'd1;
    align_prod = 54'(adj_r) * 54'(s_r);
    lim        = {9'd0, in_r.viewport_extent, 24'd0};
    pos_ext    = {1'b0, pos_r};
    step_pos   = pos_ext + 57'(vis_r);
    out_free   = !out_valid_r || out_ready;
    is_last    = (n_r == glpg_pkg::LAST_LINE) || (step_pos > lim);
    load_item  = (state_r == glpg_pkg::ST_EMIT) && (pos_ext <= lim) && out_free;
  end

  always_comb begin
    state_nxt     = state_r;
    in_nxt        = in_r;
    rh_ok_nxt     = rh_ok_r;
    ok_nxt        = ok_r;
    r_nxt         = r_r;
    diff_nxt      = diff_r;
    s_nxt         = s_r;
    minor_nxt     = minor_r;
    vis_nxt       = vis_r;
    prod_nxt      = prod_r;
    neg_nxt       = neg_r;
    first_mag_nxt = first_mag_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    adj_nxt       = adj_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    div_req.start    = 1'b0;
    div_req.dividend = {prod_mag, 8'd0};
    div_req.divisor  = s_r;
    in_ready      = 1'b0;

    unique case (state_r)
      glpg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt    = in_item;
          state_nxt = glpg_pkg::ST_RESH;
        end
      end
      glpg_pkg::ST_RESH: begin
        rh_ok_nxt = res_ok;
        if (!in_r.axis) begin
          r_nxt = res_prod[25:0];
        end
        diff_nxt  = 34'(in_r.grid_origin) - 34'(in_r.scroll_offset) +
                    (in_r.axis ? 34'sd0 : 34'(cfg.axis_offset));
        state_nxt = glpg_pkg::ST_RESV;
      end
      glpg_pkg::ST_RESV: begin
        ok_nxt = rh_ok_r && res_ok;
        if (in_r.axis) begin
          r_nxt = res_prod[25:0];
        end
        state_nxt = glpg_pkg::ST_SCALE;
      end
      glpg_pkg::ST_SCALE: begin
        s_nxt     = s_prod;
        minor_nxt = minor_cmp;
        state_nxt = go ? glpg_pkg::ST_BASE : glpg_pkg::ST_IDLE;
      end
      glpg_pkg::ST_BASE: begin
        vis_nxt   = minor_r ? 54'(s_r) : vis_prod;
        prod_nxt  = base_prod;
        state_nxt = glpg_pkg::ST_CHECK;
      end
      glpg_pkg::ST_CHECK: begin
        // visible step under one pixel gives no lines
        if (vis_r < glpg_pkg::VIS_MIN) begin
          state_nxt = glpg_pkg::ST_IDLE;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = glpg_pkg::ST_DIV;
        end
      end
      glpg_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          // first index is ceil(-base / s); the first position follows from the remainder
          if (num_pos) begin
            first_mag_nxt = div_rsp.quotient + 61'(div_rsp.remainder != '0);
            pos_nxt       = (div_rsp.remainder == '0) ? 56'd0 : 56'(s_r - div_rsp.remainder);
          end else begin
            first_mag_nxt = div_rsp.quotient;
            pos_nxt       = 56'(div_rsp.remainder);
          end
          neg_nxt   = !num_pos;
          state_nxt = glpg_pkg::ST_FIRST;
        end
      end
      glpg_pkg::ST_FIRST: begin
        div_req.start    = 1'b1;
        div_req.dividend = first_mag_r;
        div_req.divisor  = 46'(cfg.major_every);
        state_nxt        = glpg_pkg::ST_MOD;
      end
      glpg_pkg::ST_MOD: begin
        if (div_rsp.done) begin
          if (minor_r) begin
            cnt_nxt = mod_p;
            adj_nxt = 8'd0;
          end else begin
            // only major lines: step the index up to the next multiple
            cnt_nxt = 8'd0;
            adj_nxt = (mod_p == 8'd0) ? 8'd0 : (cfg.major_every - mod_p);
          end
          state_nxt = glpg_pkg::ST_ALIGN;
        end
      end
      glpg_pkg::ST_ALIGN: begin
        pos_nxt   = pos_r + 56'(align_prod);
        n_nxt     = '0;
        state_nxt = glpg_pkg::ST_EMIT;
      end
      glpg_pkg::ST_EMIT: begin
        if (pos_ext > lim) begin
          state_nxt = glpg_pkg::ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_item_nxt.position = pos_r[47:24];
          out_item_nxt.is_major = (cnt_r == 8'd0);
          out_item_nxt.last     = is_last;
          pos_nxt               = step_pos[55:0];
          n_nxt                 = n_r + 1'b1;
          if (minor_r) begin
            cnt_nxt = (cnt_inc == cfg.major_every) ? 8'd0 : cnt_inc;
          end
          if (is_last) begin
            state_nxt = glpg_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = glpg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= glpg_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r        <= in_nxt;
    rh_ok_r     <= rh_ok_nxt;
    ok_r        <= ok_nxt;
    r_r         <= r_nxt;
    diff_r      <= diff_nxt;
    s_r         <= s_nxt;
    minor_r     <= minor_nxt;
    vis_r       <= vis_nxt;
    prod_r      <= prod_nxt;
    neg_r       <= neg_nxt;
    first_mag_r <= first_mag_nxt;
    pos_r       <= pos_nxt;
    cnt_r       <= cnt_nxt;
    adj_r       <= adj_nxt;
    n_r         <= n_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // divider results only turn up while the sequencer waits for them
  a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == glpg_pkg::ST_DIV || state_r == glpg_pkg::ST_MOD))
    else $error("divider result arrived outside a wait state");

  // a line marked last closes the request
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load_item && is_last) |=> (state_r == glpg_pkg::ST_IDLE))
    else $error("request continued after its last line");

  // no new request is taken while lines are being output
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == glpg_pkg::ST_EMIT) |-> !in_ready)
    else $error("input taken during line output");

  // every emitted line lies inside the viewport
  a_in_view: assert property (@(posedge clk) disable iff (!rst_n)
    load_item |-> (pos_ext <= lim))
    else $error("line emitted beyond the viewport end");

endmodule
